>>> design/assert_macros.svh
// Assertion macros shared by the calendar unit's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is held low.
`define SCC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never hold at a clock edge.
`define SCC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `SCC_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

>>> design/scc_pkg.sv
// Types, constants and helper functions of the scaled clock calendar unit.
package scc_pkg;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
  localparam logic [6:0]  YEARS_PER_CENT = 7'd100;

  // Reciprocals for exact floor division by constants: q = (x * R) >> S.
  // ms -> s: x / 1000 over 32 bits.
  localparam logic [28:0] RECIP_1000 = 29'd274877907;
  localparam int unsigned SH_1000    = 38;
  // (x >> 7) / 675 gives x / 86400.
  localparam logic [25:0] RECIP_675  = 26'd50903317;
  localparam int unsigned SH_675     = 35;
  // (x >> 4) / 225 gives x / 3600.
  localparam logic [13:0] RECIP_225  = 14'd9321;
  localparam int unsigned SH_225     = 21;
  // (x >> 2) / 15 gives x / 60.
  localparam logic [10:0] RECIP_15   = 11'd1093;
  localparam int unsigned SH_15      = 14;
  // (y >> 2) / 25 gives y / 100.
  localparam logic [14:0] RECIP_25   = 15'd20972;
  localparam int unsigned SH_25      = 19;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEC,
    ST_SCALE,
    ST_DAY,
    ST_DREM,
    ST_HOUR,
    ST_HREM,
    ST_MIN,
    ST_FIN
  } scc_state_t;

  // One queued command, already classified.
  typedef struct packed {
    logic        is_load;
    logic [31:0] time_ms;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } scc_cmd_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [15:0] day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } scc_result_t;

  // Days in a month, non-leap; codes outside one to twelve give zero.
  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

>>> design/scc_if.sv
// Valid/ready channel interfaces of the scaled clock calendar unit.
interface scc_in_if ();
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] time_ms;
  logic [15:0] start_year;
  logic [3:0]  start_month;
  logic [4:0]  start_day;
  logic [4:0]  start_hour;
  logic [5:0]  start_minute;
  logic [5:0]  start_second;

  modport source (
    output valid, func, time_ms, start_year, start_month, start_day,
           start_hour, start_minute, start_second,
    input  ready
  );
  modport sink (
    input  valid, func, time_ms, start_year, start_month, start_day,
           start_hour, start_minute, start_second,
    output ready
  );
endinterface

interface scc_out_if ();
  logic        valid;
  logic        ready;
  logic [15:0] cur_year;
  logic [3:0]  cur_month;
  logic [15:0] cur_day;
  logic [4:0]  cur_hour;
  logic [5:0]  cur_minute;
  logic [5:0]  cur_second;

  modport source (
    output valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
    input  ready
  );
  modport sink (
    input  valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
    output ready
  );
endinterface

interface scc_cfg_if ();
  logic       valid;
  logic       ready;
  logic [9:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> design/scaled_clock_calendar_unit.sv
// Top level of the scaled clock calendar unit: front queue, back datapath, ratio register.
//
// Usage:
//   in_ch  : valid/ready input beats. func = 0 loads a base tick and base date and
//            time (no result); func = 1 updates from the current millisecond tick.
//   out_ch : valid/ready result beats, one per update beat, in order: year,
//            month, day, hour, minute and second.
//   cfg_ch : writes time_ratio (game seconds per real second); always ready.
//            Write it only while no beat is in flight.
// Sequence: an update beat passes in the back end through an idle pick-up, then
//   eight sequencer steps: seconds, scaling, day, hour and minute divisions by
//   reciprocal multiply and their remainders, calendar carry; a load is applied at the pick-up.
//   The sequence is set by one multiply path per step and by the base date,
//   which a carry rebases before the next beat may use it.
//   The input queue (QUEUE_DEPTH beats) keeps in_ch ready while the back end works.
// Reset: rst_n low clears the base to zero, time_ratio to one, and empties the queue.
// Stall: a result held in the output register blocks the back end at its final step;
//   the queue then fills and in_ch.ready drops when it is full.
module scaled_clock_calendar_unit import scc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  scc_in_if.sink    in_ch,
  scc_out_if.source out_ch,
  scc_cfg_if.sink   cfg_ch
);

  logic       cmd_valid;
  logic       cmd_pop;
  scc_cmd_t   cmd;
  logic [9:0] ratio_r;

  // Ratio register: written whenever a config beat arrives.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= 10'd1;
    end else if (cfg_ch.valid) begin
      ratio_r <= cfg_ch.data;
    end
  end

  // Front: accept and classify beats into the queue.
  scc_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Back: hold the base, run the division sequence and drive results.
  scc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ratio     (ratio_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

endmodule

>>> design/scc_front.sv
// Front end: accept input beats, classify them and hold them in a short queue.
`include "assert_macros.svh"

module scc_front import scc_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  scc_in_if.sink    in_ch,
  output logic      cmd_valid,
  output scc_cmd_t  cmd,
  input  logic      cmd_pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  scc_cmd_t         q_mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;
  scc_cmd_t         entry;

  assign in_ch.ready = (cnt_r != FULL_CNT);
  assign push        = in_ch.valid & in_ch.ready;
  assign cmd_valid   = (cnt_r != '0);
  assign pop         = cmd_pop & cmd_valid;
  assign cmd         = q_mem_r[rd_ptr_r];

  // Classify: anything that is not an update is a load of the base.
  always_comb begin
    entry.is_load = (in_ch.func == FUNC_LOAD);
    entry.time_ms = in_ch.time_ms;
    entry.year    = in_ch.start_year;
    entry.month   = in_ch.start_month;
    entry.day     = in_ch.start_day;
    entry.hour    = in_ch.start_hour;
    entry.minute  = in_ch.start_minute;
    entry.second  = in_ch.start_second;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= entry;
    end
  end

  `SCC_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= FULL_CNT, "queue count beyond depth")
  `SCC_ASSERT(a_pass_through, clk, rst_n, (push && pop) |=> $stable(cnt_r), "count moved on push with pop")
  `SCC_ASSERT_NEVER(a_pop_empty, clk, rst_n, cmd_pop && (cnt_r == '0), "pop from empty queue")

endmodule

>>> design/scc_back.sv
// Back end: sequenced constant-division datapath, calendar carry and result register.
`include "assert_macros.svh"

module scc_back import scc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [9:0] ratio,
  input  logic       cmd_valid,
  input  scc_cmd_t   cmd,
  output logic       cmd_pop,
  scc_out_if.source  out_ch
);

  scc_state_t  state_r, state_nxt;

  logic [31:0] base_ms_r;
  logic [15:0] base_year_r;
  logic [3:0]  base_month_r;
  logic [15:0] base_day_r;
  logic [4:0]  base_hour_r;
  logic [5:0]  base_minute_r;
  logic [5:0]  base_second_r;

  logic [31:0] now_r;
  logic [31:0] acc_r;
  logic [15:0] d_r;
  logic [4:0]  h_r;
  logic [5:0]  m_r;
  logic [9:0]  q100_r;
  logic        leap_r;

  logic        out_valid_r, out_valid_nxt;
  scc_result_t res_r, res_nxt;

  logic        load_go, fin_go, fin_fire, carry;
  logic [31:0] diff;
  logic [60:0] sec_prod;
  logic [16:0] tod;
  logic [33:0] scale_sum;
  logic [50:0] day_prod;
  logic [32:0] drem;
  logic [26:0] hour_prod;
  logic [16:0] hrem;
  logic [20:0] min_prod;
  logic [11:0] srem;
  logic [28:0] cent_prod;
  logic        is_cent;
  logic [4:0]  days;
  logic [16:0] day_sum, day_sub;

  // Datapath terms; each state consumes the ones for its own step.
  assign diff      = now_r - base_ms_r;
  assign sec_prod  = 61'(diff) * 61'(RECIP_1000);
  assign tod       = 17'(base_second_r) + 17'(base_minute_r) * 17'(SECS_PER_MIN)
                   + 17'(base_hour_r) * 17'(SECS_PER_HOUR);
  assign scale_sum = 34'(acc_r[22:0]) * 34'(ratio) + 34'(tod);
  assign day_prod  = 51'(acc_r[31:7]) * 51'(RECIP_675);
  assign drem      = 33'(acc_r) - 33'(d_r) * 33'(SECS_PER_DAY);
  assign hour_prod = 27'(acc_r[16:4]) * 27'(RECIP_225);
  assign hrem      = acc_r[16:0] - 17'(h_r) * 17'(SECS_PER_HOUR);
  assign min_prod  = 21'(acc_r[11:2]) * 21'(RECIP_15);
  assign srem      = acc_r[11:0] - 12'(m_r) * 12'(SECS_PER_MIN);

  // Gregorian leap test via year / 100.
  assign cent_prod = 29'(base_year_r[15:2]) * 29'(RECIP_25);
  assign is_cent   = (base_year_r == 16'(q100_r) * 16'(YEARS_PER_CENT));

  // Calendar carry of at most one month.
  assign days    = month_len(base_month_r)
                 + 5'((leap_r && (base_month_r == MONTH_FEB)) ? 1 : 0);
  assign day_sum = 17'(base_day_r) + 17'(d_r);
  assign carry   = (day_sum > 17'(days));
  assign day_sub = day_sum - 17'(days);

  always_comb begin
    res_nxt.hour   = h_r;
    res_nxt.minute = m_r;
    res_nxt.second = srem[5:0];
    if (carry) begin
      res_nxt.day = day_sub[16] ? 16'hFFFF : day_sub[15:0];
      if (base_month_r == MONTH_DEC) begin
        res_nxt.month = MONTH_JAN;
        res_nxt.year  = base_year_r + 16'd1;
      end else begin
        res_nxt.month = base_month_r + 4'd1;
        res_nxt.year  = base_year_r;
      end
    end else begin
      res_nxt.day   = day_sum[15:0];
      res_nxt.month = base_month_r;
      res_nxt.year  = base_year_r;
    end
  end

  assign fin_go = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    cmd_pop   = 1'b0;
    load_go   = 1'b0;
    fin_fire  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.is_load) begin
            load_go = 1'b1;
          end else begin
            state_nxt = ST_SEC;
          end
        end
      end
      ST_SEC:   state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_DAY;
      ST_DAY:   state_nxt = ST_DREM;
      ST_DREM:  state_nxt = ST_HOUR;
      ST_HOUR:  state_nxt = ST_HREM;
      ST_HREM:  state_nxt = ST_MIN;
      ST_MIN:   state_nxt = ST_FIN;
      ST_FIN: begin
        if (fin_go) begin
          fin_fire  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = fin_fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Base date and time: load, or rebase on a month carry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_ms_r     <= '0;
      base_year_r   <= '0;
      base_month_r  <= '0;
      base_day_r    <= '0;
      base_hour_r   <= '0;
      base_minute_r <= '0;
      base_second_r <= '0;
    end else if (load_go) begin
      base_ms_r     <= cmd.time_ms;
      base_year_r   <= cmd.year;
      base_month_r  <= cmd.month;
      base_day_r    <= 16'(cmd.day);
      base_hour_r   <= cmd.hour;
      base_minute_r <= cmd.minute;
      base_second_r <= cmd.second;
    end else if (fin_fire && carry) begin
      base_ms_r     <= now_r;
      base_year_r   <= res_nxt.year;
      base_month_r  <= res_nxt.month;
      base_day_r    <= res_nxt.day;
      base_hour_r   <= res_nxt.hour;
      base_minute_r <= res_nxt.minute;
      base_second_r <= res_nxt.second;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      now_r <= cmd.time_ms;
    end
    unique case (state_r)
      ST_SEC: begin
        acc_r  <= 32'(sec_prod[SH_1000 +: 23]);
        q100_r <= cent_prod[SH_25 +: 10];
      end
      ST_SCALE: begin
        acc_r  <= scale_sum[31:0];
        leap_r <= ((base_year_r[1:0] == 2'd0) && !is_cent)
                  || (is_cent && (q100_r[1:0] == 2'd0));
      end
      ST_DAY:  d_r   <= day_prod[SH_675 +: 16];
      ST_DREM: acc_r <= 32'(drem[16:0]);
      ST_HOUR: h_r   <= hour_prod[SH_225 +: 5];
      ST_HREM: acc_r <= 32'(hrem[11:0]);
      ST_MIN:  m_r   <= min_prod[SH_15 +: 6];
      default: ;
    endcase
    if (fin_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cur_year   = res_r.year;
  assign out_ch.cur_month  = res_r.month;
  assign out_ch.cur_day    = res_r.day;
  assign out_ch.cur_hour   = res_r.hour;
  assign out_ch.cur_minute = res_r.minute;
  assign out_ch.cur_second = res_r.second;

  `SCC_ASSERT(a_pop_idle, clk, rst_n, cmd_pop |-> (state_r == ST_IDLE), "command taken mid-sequence")
  `SCC_ASSERT(a_fin_hold, clk, rst_n, ((state_r == ST_FIN) && !fin_go) |=> (state_r == ST_FIN), "finish dropped while result blocked")
  `SCC_ASSERT(a_base_quiet, clk, rst_n, ((state_r != ST_IDLE) && (state_r != ST_FIN)) |=> $stable(base_ms_r), "base tick changed mid-sequence")

endmodule
